/* rtl/core/smr_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the stereo reverb.
// Used by the controller, the datapath, the top level and the checker.
package smr_pkg;

  localparam int SAMPLE_W = 24;
  localparam int EARLY_W = 28;
  localparam int SUM_W = 32;
  localparam int TMP_W = 34;
  localparam int MA_W = 18;
  localparam int PROD_W = 52;
  localparam int ADDR_W = 14;
  localparam int DEPTH = 16384;
  localparam int NTAP = 6;
  localparam int LINE2_DEPTH = 2 * DEPTH;
  localparam int COMB_DEPTH = 2 * NTAP * DEPTH;
  localparam int LINE2_AW = 15;
  localparam int COMB_AW = 18;
  localparam int CFG_W = 16;
  localparam int CFG_AW = 2;

  localparam logic [ADDR_W-1:0] AP_LEN = 14'd288;
  localparam logic [ADDR_W-1:0] LATE_LEN = 14'd1392;
  localparam logic signed [MA_W-1:0] AP_GAIN = 18'sd22938;
  localparam logic signed [MA_W-1:0] OUT_GAIN = 18'sd4915;
  localparam logic signed [MA_W-1:0] UNITY = 18'sd32768;
  localparam logic [COMB_AW-1:0] CLR_LAST = 18'(COMB_DEPTH - 1);
  localparam logic [2:0] TAP_LAST = 3'(NTAP - 1);

  localparam logic [CFG_AW-1:0] CFG_REVERB_GAIN = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_PREDELAY = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_DAMPING = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_WET_MIX = 2'd3;

  typedef logic [4:0] op_t;
  localparam op_t OP_NONE    = 5'd0;
  localparam op_t OP_LOAD    = 5'd1;
  localparam op_t OP_FIR_RD  = 5'd2;
  localparam op_t OP_FIR_MUL = 5'd3;
  localparam op_t OP_FIR_ACC = 5'd4;
  localparam op_t OP_EARLY   = 5'd5;
  localparam op_t OP_G_MUL   = 5'd6;
  localparam op_t OP_G_SET   = 5'd7;
  localparam op_t OP_T_MUL   = 5'd8;
  localparam op_t OP_INNER   = 5'd9;
  localparam op_t OP_LP_MUL  = 5'd10;
  localparam op_t OP_LP      = 5'd11;
  localparam op_t OP_Y_MUL   = 5'd12;
  localparam op_t OP_Y       = 5'd13;
  localparam op_t OP_SUM     = 5'd14;
  localparam op_t OP_AP_MUL1 = 5'd15;
  localparam op_t OP_AP_ACC1 = 5'd16;
  localparam op_t OP_AP_ACC2 = 5'd17;
  localparam op_t OP_AP_WR   = 5'd18;
  localparam op_t OP_LATE_RD = 5'd19;
  localparam op_t OP_O_ADD   = 5'd20;
  localparam op_t OP_O_MUL   = 5'd21;
  localparam op_t OP_O       = 5'd22;
  localparam op_t OP_F_MUL1  = 5'd23;
  localparam op_t OP_F_MUL2  = 5'd24;
  localparam op_t OP_F_SUM   = 5'd25;
  localparam op_t OP_RES     = 5'd26;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } out_item_t;

  typedef struct packed {
    op_t op;
    logic [2:0] tap;
    logic ch;
    logic capture;
    logic clr_en;
    logic [COMB_AW-1:0] clr_idx;
    logic load_out;
  } dp_cmd_t;

  function automatic logic [ADDR_W-1:0] fir_offset(logic [2:0] i);
    case (i)
      3'd0: return 14'd0;
      3'd1: return 14'd744;
      3'd2: return 14'd912;
      3'd3: return 14'd1032;
      3'd4: return 14'd2400;
      3'd5: return 14'd2866;
      default: return 14'd0;
    endcase
  endfunction

  function automatic logic signed [MA_W-1:0] fir_gain(logic [2:0] i);
    case (i)
      3'd0: return 18'sd30179;
      3'd1: return 18'sd26804;
      3'd2: return 18'sd20808;
      3'd3: return 18'sd23560;
      3'd4: return 18'sd8749;
      3'd5: return 18'sd7930;
      default: return 18'sd0;
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] comb_len(logic [2:0] i);
    case (i)
      3'd0: return 14'd2400;
      3'd1: return 14'd2688;
      3'd2: return 14'd2928;
      3'd3: return 14'd3264;
      3'd4: return 14'd3456;
      3'd5: return 14'd3744;
      default: return 14'd2400;
    endcase
  endfunction

  function automatic logic signed [TMP_W-1:0] comb_coef(logic [2:0] i);
    case (i)
      3'd0: return 34'sd15073;
      3'd1: return 34'sd15729;
      3'd2: return 34'sd16384;
      3'd3: return 34'sd17039;
      3'd4: return 34'sd17367;
      3'd5: return 34'sd18022;
      default: return 34'sd0;
    endcase
  endfunction

  function automatic logic signed [PROD_W-1:0] rshr15(logic signed [PROD_W-1:0] v);
    return (v + 52'sd16384) >>> 15;
  endfunction

  function automatic logic signed [PROD_W-1:0] rshr14(logic signed [PROD_W-1:0] v);
    return (v + 52'sd8192) >>> 14;
  endfunction

  function automatic logic signed [EARLY_W-1:0] sat28(logic signed [PROD_W-1:0] v);
    if (v > 52'sd134217727) return 28'sh7FFFFFF;
    else if (v < -52'sd134217728) return 28'sh8000000;
    else return v[EARLY_W-1:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] sat32(logic signed [PROD_W-1:0] v);
    if (v > 52'sd2147483647) return 32'sh7FFFFFFF;
    else if (v < -52'sd2147483648) return 32'sh80000000;
    else return v[SUM_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat24(logic signed [PROD_W-1:0] v);
    if (v > 52'sd8388607) return 24'sh7FFFFF;
    else if (v < -52'sd8388608) return 24'sh800000;
    else return v[SAMPLE_W-1:0];
  endfunction

endpackage

/* rtl/core/stereo_moorer_reverb.sv */
`timescale 1ns / 1ps
// Top level of the stereo Moorer reverb: controller plus datapath.
// Depends on smr_pkg, smr_ctrl and smr_datapath.
//
//   channel  direction  handshake               payload
//   in_      input      in_valid / in_stall     smr_pkg::in_item_t
//   out_     output     out_valid / out_stall   smr_pkg::out_item_t
//   cfg_     input      cfg_we                  cfg_addr, cfg_wdata
//
// A frame runs as a sequence of operations per channel around the single shared
// multiplier; no new frame is taken until the finished one is loaded for output.
// After reset a sweep zeroes the delay lines, one comb entry per cycle, and
// in_stall stays high during it. A finished frame waits in the
// output register, so a stalled output holds the block only at its last step.
module stereo_moorer_reverb (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  smr_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output smr_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [smr_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [smr_pkg::CFG_W-1:0]     cfg_wdata
);

  smr_pkg::dp_cmd_t cmd;

  smr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  smr_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

endmodule

/* rtl/core/smr_ctrl.sv */
`timescale 1ns / 1ps
// Sequencing state machine for the stereo reverb: clearing sweep, handshakes
// and the per-channel operation sequence. Depends on smr_pkg.
module smr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output smr_pkg::dp_cmd_t  cmd
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_r, state_nxt;
  smr_pkg::op_t op_r, op_nxt;
  logic [2:0] tap_r, tap_nxt;
  logic ch_r, ch_nxt;
  logic [smr_pkg::COMB_AW-1:0] clr_r, clr_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept, load_out;
  logic tap_end;

  assign in_stall = (state_r != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign load_out = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign tap_end = (tap_r == smr_pkg::TAP_LAST);

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    tap_nxt = tap_r;
    ch_nxt = ch_r;
    clr_nxt = clr_r;
    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == smr_pkg::CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RUN;
          op_nxt = smr_pkg::OP_LOAD;
          tap_nxt = 3'd0;
          ch_nxt = 1'b0;
        end
      end
      S_RUN: begin
        op_nxt = op_r + 1'b1;
        case (op_r)
          smr_pkg::OP_FIR_ACC: begin
            if (!tap_end) begin
              tap_nxt = tap_r + 1'b1;
              op_nxt = smr_pkg::OP_FIR_RD;
            end else begin
              tap_nxt = 3'd0;
            end
          end
          smr_pkg::OP_Y: begin
            if (!tap_end) begin
              tap_nxt = tap_r + 1'b1;
              op_nxt = smr_pkg::OP_G_MUL;
            end else begin
              tap_nxt = 3'd0;
            end
          end
          smr_pkg::OP_RES: begin
            if (!ch_r) begin
              ch_nxt = 1'b1;
              op_nxt = smr_pkg::OP_LOAD;
            end else begin
              state_nxt = S_DONE;
              op_nxt = smr_pkg::OP_NONE;
            end
          end
          default: begin
          end
        endcase
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      op_r <= smr_pkg::OP_NONE;
      tap_r <= 3'd0;
      ch_r <= 1'b0;
      clr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
      tap_r <= tap_nxt;
      ch_r <= ch_nxt;
      clr_r <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd.op = (state_r == S_RUN) ? op_r : smr_pkg::OP_NONE;
    cmd.tap = tap_r;
    cmd.ch = ch_r;
    cmd.capture = accept;
    cmd.clr_en = (state_r == S_CLEAR);
    cmd.clr_idx = clr_r;
    cmd.load_out = load_out;
  end

endmodule

/* rtl/core/smr_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the stereo reverb: delay-line memories, the shared multiplier,
// working registers and configuration registers. Depends on smr_pkg.
module smr_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  smr_pkg::dp_cmd_t              cmd,
  input  smr_pkg::in_item_t             in_data,
  input  logic                          cfg_we,
  input  logic [smr_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [smr_pkg::CFG_W-1:0]     cfg_wdata,
  output smr_pkg::out_item_t            out_data
);

  logic [15:0] rg_r;
  logic [12:0] pd_r;
  logic [14:0] damp_r;
  logic [15:0] wet_r;
  logic [smr_pkg::ADDR_W-1:0] wp_r;

  smr_pkg::in_item_t in_r;
  smr_pkg::out_item_t out_r, out_nxt;
  logic signed [smr_pkg::PROD_W-1:0] acc_r, acc_nxt, prod_r, prod_nxt, mul_p;
  logic signed [smr_pkg::TMP_W-1:0] tmp_r, tmp_nxt, mul_b;
  logic signed [smr_pkg::MA_W-1:0] g_r, g_nxt, mul_a;
  logic signed [smr_pkg::EARLY_W-1:0] xd_r, xd_nxt, early_r, early_nxt;
  logic signed [smr_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic signed [smr_pkg::SAMPLE_W-1:0] x_r, x_nxt, res0_r, res0_nxt, res1_r, res1_nxt;
  logic signed [smr_pkg::SAMPLE_W-1:0] x_sel, res_val;
  logic signed [smr_pkg::EARLY_W-1:0] y_val, early_val;
  logic signed [smr_pkg::SUM_W-1:0] ap_val;

  logic signed [smr_pkg::SAMPLE_W-1:0] dry_mem [smr_pkg::LINE2_DEPTH];
  logic signed [smr_pkg::EARLY_W-1:0] early_mem [smr_pkg::LINE2_DEPTH];
  logic signed [smr_pkg::EARLY_W-1:0] comb_mem [smr_pkg::COMB_DEPTH];
  logic signed [smr_pkg::SUM_W-1:0] csum_mem [smr_pkg::LINE2_DEPTH];
  logic signed [smr_pkg::SUM_W-1:0] ap_mem [smr_pkg::LINE2_DEPTH];

  logic signed [smr_pkg::SAMPLE_W-1:0] dry_q, dry_wd;
  logic signed [smr_pkg::EARLY_W-1:0] early_q, early_wd, comb_q, comb_wd;
  logic signed [smr_pkg::SUM_W-1:0] csum_q, csum_wd, ap_q, ap_wd;
  logic dry_we, early_we, comb_we, csum_we, ap_we;
  logic [smr_pkg::LINE2_AW-1:0] dry_wa, early_wa, csum_wa, ap_wa;
  logic [smr_pkg::LINE2_AW-1:0] dry_ra, early_ra, csum_ra, ap_ra;
  logic [smr_pkg::COMB_AW-1:0] comb_wa, comb_ra;

  logic [smr_pkg::ADDR_W-1:0] fir_d, fir_a, late_d, late_a, comb_a, comb_a1, apd_a;
  logic [3:0] comb_row;
  logic line_clr;

  assign fir_d = {1'b0, pd_r} + smr_pkg::fir_offset(cmd.tap);
  assign fir_a = wp_r - fir_d;
  assign late_d = {1'b0, pd_r} + smr_pkg::LATE_LEN;
  assign late_a = wp_r - late_d;
  assign comb_a = wp_r - smr_pkg::comb_len(cmd.tap);
  assign comb_a1 = comb_a - 14'd1;
  assign apd_a = wp_r - smr_pkg::AP_LEN;
  assign comb_row = cmd.ch ? (4'd6 + {1'b0, cmd.tap}) : {1'b0, cmd.tap};
  assign line_clr = cmd.clr_en && (cmd.clr_idx[17:15] == 3'd0);

  assign dry_ra = {cmd.ch, fir_a};
  assign early_ra = {cmd.ch, comb_a};
  assign csum_ra = {cmd.ch, apd_a};
  assign ap_ra = {cmd.ch, (cmd.op == smr_pkg::OP_LATE_RD) ? late_a : apd_a};
  assign comb_ra = {comb_row, (cmd.op == smr_pkg::OP_G_MUL) ? comb_a1 : comb_a};

  assign x_sel = cmd.ch ? in_r.right_in : in_r.left_in;
  assign y_val = smr_pkg::sat28(smr_pkg::rshr15(prod_r));
  assign early_val = smr_pkg::sat28(acc_r);
  assign ap_val = smr_pkg::sat32(acc_r);
  assign res_val = smr_pkg::sat24(smr_pkg::rshr15(acc_r));
  assign mul_p = mul_a * mul_b;

  always_comb begin
    dry_we = line_clr || (cmd.op == smr_pkg::OP_LOAD);
    early_we = line_clr || (cmd.op == smr_pkg::OP_EARLY);
    csum_we = line_clr || (cmd.op == smr_pkg::OP_SUM);
    ap_we = line_clr || (cmd.op == smr_pkg::OP_AP_WR);
    comb_we = cmd.clr_en || (cmd.op == smr_pkg::OP_Y);
    dry_wa = cmd.clr_en ? cmd.clr_idx[14:0] : {cmd.ch, wp_r};
    early_wa = dry_wa;
    csum_wa = dry_wa;
    ap_wa = dry_wa;
    comb_wa = cmd.clr_en ? cmd.clr_idx : {comb_row, wp_r};
    dry_wd = cmd.clr_en ? '0 : x_sel;
    early_wd = cmd.clr_en ? '0 : early_val;
    comb_wd = cmd.clr_en ? '0 : y_val;
    csum_wd = cmd.clr_en ? '0 : sum_r;
    ap_wd = cmd.clr_en ? '0 : ap_val;
  end

  always_ff @(posedge clk) begin
    if (dry_we) begin
      dry_mem[dry_wa] <= dry_wd;
    end
    dry_q <= dry_mem[dry_ra];
  end

  always_ff @(posedge clk) begin
    if (early_we) begin
      early_mem[early_wa] <= early_wd;
    end
    early_q <= early_mem[early_ra];
  end

  always_ff @(posedge clk) begin
    if (comb_we) begin
      comb_mem[comb_wa] <= comb_wd;
    end
    comb_q <= comb_mem[comb_ra];
  end

  always_ff @(posedge clk) begin
    if (csum_we) begin
      csum_mem[csum_wa] <= csum_wd;
    end
    csum_q <= csum_mem[csum_ra];
  end

  always_ff @(posedge clk) begin
    if (ap_we) begin
      ap_mem[ap_wa] <= ap_wd;
    end
    ap_q <= ap_mem[ap_ra];
  end

  always_comb begin
    acc_nxt = acc_r;
    prod_nxt = prod_r;
    tmp_nxt = tmp_r;
    g_nxt = g_r;
    xd_nxt = xd_r;
    early_nxt = early_r;
    sum_nxt = sum_r;
    x_nxt = x_r;
    res0_nxt = res0_r;
    res1_nxt = res1_r;
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      smr_pkg::OP_LOAD: begin
        x_nxt = x_sel;
        acc_nxt = smr_pkg::PROD_W'(x_sel);
      end
      smr_pkg::OP_FIR_MUL: begin
        mul_a = smr_pkg::fir_gain(cmd.tap);
        mul_b = smr_pkg::TMP_W'(dry_q);
        prod_nxt = mul_p;
      end
      smr_pkg::OP_FIR_ACC: acc_nxt = acc_r + smr_pkg::rshr15(prod_r);
      smr_pkg::OP_EARLY: begin
        early_nxt = early_val;
        sum_nxt = '0;
      end
      smr_pkg::OP_G_MUL: begin
        mul_a = smr_pkg::MA_W'({1'b0, damp_r});
        mul_b = smr_pkg::comb_coef(cmd.tap);
        prod_nxt = mul_p;
      end
      smr_pkg::OP_G_SET: begin
        g_nxt = smr_pkg::MA_W'(smr_pkg::rshr14(prod_r));
        tmp_nxt = smr_pkg::TMP_W'(comb_q);
      end
      smr_pkg::OP_T_MUL: begin
        mul_a = g_r;
        mul_b = tmp_r;
        prod_nxt = mul_p;
        tmp_nxt = smr_pkg::TMP_W'(comb_q);
      end
      smr_pkg::OP_INNER: begin
        tmp_nxt = tmp_r + smr_pkg::TMP_W'(smr_pkg::rshr15(prod_r));
        xd_nxt = early_q;
      end
      smr_pkg::OP_LP_MUL: begin
        mul_a = smr_pkg::UNITY - g_r;
        mul_b = tmp_r;
        prod_nxt = mul_p;
      end
      smr_pkg::OP_LP: begin
        tmp_nxt = smr_pkg::TMP_W'(xd_r) + smr_pkg::TMP_W'(smr_pkg::rshr15(prod_r));
      end
      smr_pkg::OP_Y_MUL: begin
        mul_a = smr_pkg::MA_W'({1'b0, rg_r});
        mul_b = tmp_r;
        prod_nxt = mul_p;
      end
      smr_pkg::OP_Y: sum_nxt = sum_r + smr_pkg::SUM_W'(y_val);
      smr_pkg::OP_AP_MUL1: begin
        mul_a = smr_pkg::AP_GAIN;
        mul_b = smr_pkg::TMP_W'(sum_r);
        prod_nxt = mul_p;
        acc_nxt = smr_pkg::PROD_W'(csum_q);
      end
      smr_pkg::OP_AP_ACC1: begin
        acc_nxt = acc_r - smr_pkg::rshr15(prod_r);
        mul_a = smr_pkg::AP_GAIN;
        mul_b = smr_pkg::TMP_W'(ap_q);
        prod_nxt = mul_p;
      end
      smr_pkg::OP_AP_ACC2: acc_nxt = acc_r + smr_pkg::rshr15(prod_r);
      smr_pkg::OP_O_ADD: tmp_nxt = smr_pkg::TMP_W'(early_r) + smr_pkg::TMP_W'(ap_q);
      smr_pkg::OP_O_MUL: begin
        mul_a = smr_pkg::OUT_GAIN;
        mul_b = tmp_r;
        prod_nxt = mul_p;
      end
      smr_pkg::OP_O: tmp_nxt = smr_pkg::TMP_W'(smr_pkg::rshr15(prod_r));
      smr_pkg::OP_F_MUL1: begin
        mul_a = smr_pkg::UNITY - smr_pkg::MA_W'({1'b0, wet_r});
        mul_b = smr_pkg::TMP_W'(x_r);
        prod_nxt = mul_p;
      end
      smr_pkg::OP_F_MUL2: begin
        acc_nxt = prod_r;
        mul_a = smr_pkg::MA_W'({1'b0, wet_r});
        mul_b = tmp_r;
        prod_nxt = mul_p;
      end
      smr_pkg::OP_F_SUM: acc_nxt = acc_r + prod_r;
      smr_pkg::OP_RES: begin
        if (cmd.ch) begin
          res1_nxt = res_val;
        end else begin
          res0_nxt = res_val;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_nxt = out_r;
    if (cmd.load_out) begin
      out_nxt.left_out = res0_r;
      out_nxt.right_out = res1_r;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    prod_r <= prod_nxt;
    tmp_r <= tmp_nxt;
    g_r <= g_nxt;
    xd_r <= xd_nxt;
    early_r <= early_nxt;
    sum_r <= sum_nxt;
    x_r <= x_nxt;
    res0_r <= res0_nxt;
    res1_r <= res1_nxt;
    out_r <= out_nxt;
    if (cmd.capture) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rg_r <= 16'd28672;
      pd_r <= 13'd960;
      damp_r <= 15'd11469;
      wet_r <= 16'd32768;
      wp_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          smr_pkg::CFG_REVERB_GAIN: rg_r <= cfg_wdata;
          smr_pkg::CFG_PREDELAY: pd_r <= cfg_wdata[12:0];
          smr_pkg::CFG_DAMPING: damp_r <= cfg_wdata[14:0];
          smr_pkg::CFG_WET_MIX: wet_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (cmd.load_out) begin
        wp_r <= wp_r + 1'b1;
      end
    end
  end

  assign out_data = out_r;

endmodule

/* rtl/core/smr_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the stereo reverb, bound to the top level.
// Depends on smr_pkg.
module smr_port_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input smr_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("Stalled result transaction was dropped.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("Stalled result payload changed.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("Input taken while a frame is in progress.");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("Input open before the delay lines were cleared.");

endmodule

bind stereo_moorer_reverb smr_port_checker u_smr_port_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
